// ===== rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit allocator: table sizes,
// command codes and the entry layouts of the free table and request log.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int FT_DEPTH  = 256;
	localparam int FT_AW     = 8;
	localparam int LOG_DEPTH = 4096;
	localparam int LOG_AW    = 12;
	localparam int CNT_W     = 13;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [30:0] MEM_SIZE_RST = 31'd1024;

	typedef struct packed {
		logic [30:0] start;
		logic [30:0] size;
		logic [31:0] stamp;
	} ft_entry_t;

	typedef struct packed {
		logic [30:0] start;
		logic [30:0] size;
		logic        ok;
	} log_entry_t;

	localparam int FT_W  = $bits(ft_entry_t);
	localparam int LOG_W = $bits(log_entry_t);

endpackage

// ===== rtl/best_fit_allocator_with_coalescing.sv =====
// ----------------------------------------------------------------------------
// best_fit_allocator_with_coalescing
// Best-fit allocator over cells 1..memory_size with merging of freed ranges.
//
// Usage:
//   Command channel: an item (command, alloc_size, request_number) is taken
//   at a clock edge with start high and busy low. Commands are numbered
//   from 1 and the first 4096 are logged in the 4096-entry request log.
//   Result channel: done pulses for one cycle with granted and start_address.
//   An allocate always gives one result; a free gives one only when the
//   free table has no room for the merged block. The receiver cannot stall.
//   Configuration: cfg_we with cfg_wdata writes memory_size and restarts the
//   allocator (one free block unless the size is zero, empty log). Write only while busy is low.
// Operation:
//   The free table lives in a 256-entry RAM read one entry per cycle, so each
//   allocate and each valid free scans the whole table. A free that is ignored
//   ends without a scan. One command at a time.
// Reset:
//   arst_n restores memory_size 1024 with one free block at cell 1. Only the
//   valid bits of the table are flip-flops, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module best_fit_allocator_with_coalescing
	import bfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [30:0] alloc_size,
	input  logic [12:0] request_number,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata,
	output logic        done,
	output logic        granted,
	output logic [30:0] start_address
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_F_CHK, ST_F_LOG, ST_SCAN, ST_A_WR, ST_F_WR, ST_F_LOGCUR
	} state_t;

	state_t state_q;

	// configuration and counters
	logic [30:0]       mem_size_q;
	logic              init0_q;
	logic [FT_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]  req_count_q;
	logic [31:0]       ins_ctr_q;

	// command fields
	logic              cmd_q;
	logic [30:0]       asked_q;
	logic [CNT_W-1:0]  target_q;

	// scan pipeline
	logic [FT_AW:0]    cnt_q;
	logic              vld_s1;
	logic [FT_AW-1:0]  idx_s1;

	// best-fit search
	logic              found_q;
	logic [FT_AW-1:0]  best_idx_q;
	ft_entry_t         best_q;

	// neighbour search
	logic [30:0]       fs_q;
	logic [30:0]       flen_q;
	logic [31:0]       fend_q;
	logic              left_q, right_q, empty_q;
	logic [FT_AW-1:0]  left_idx_q, right_idx_q, empty_idx_q;
	logic [30:0]       lstart_q, lsize_q, rsize_q;

	// result register
	logic              done_q, granted_q;
	logic [30:0]       addr_q;

	// RAM ports
	logic              ft_we;
	logic [FT_AW-1:0]  ft_waddr;
	ft_entry_t         ft_wdata;
	logic [FT_W-1:0]   ft_rdata;
	logic              log_we;
	logic [LOG_AW-1:0] log_waddr;
	log_entry_t        log_wdata;
	logic [LOG_W-1:0]  log_rdata;
	log_entry_t        log_rd;

	ft_entry_t         ent;
	logic [CNT_W-1:0]  tgt_m1;
	logic              usable;
	logic              log_room;
	logic [30:0]       rest;
	logic [30:0]       a_nstart;
	logic [30:0]       f_nstart;
	logic [31:0]       f_nsize;
	logic              f_ovf;
	logic [FT_AW-1:0]  slot_a, slot;
	logic              ent_fits, ent_better;
	logic [31:0]       ent_end;

	bfa_ram #(.W(FT_W), .AW(FT_AW)) u_ft_ram (
		.clk   (clk),
		.we    (ft_we),
		.waddr (ft_waddr),
		.wdata (ft_wdata),
		.raddr (cnt_q[FT_AW-1:0]),
		.rdata (ft_rdata)
	);

	bfa_ram #(.W(LOG_W), .AW(LOG_AW)) u_log_ram (
		.clk   (clk),
		.we    (log_we),
		.waddr (log_waddr),
		.wdata (log_wdata),
		.raddr (tgt_m1[LOG_AW-1:0]),
		.rdata (log_rdata)
	);

	// read data, entry 0 shows the initial block until first written
	always_comb begin
		log_rd = log_entry_t'(log_rdata);
		if (idx_s1 == '0 && init0_q) begin
			ent.start = 31'd1;
			ent.size  = mem_size_q;
			ent.stamp = '0;
		end else begin
			ent = ft_entry_t'(ft_rdata);
		end
	end

	// per-beat compares
	always_comb begin
		tgt_m1     = target_q - CNT_W'(1);
		usable     = (target_q != '0) && (target_q <= req_count_q);
		log_room   = req_count_q < CNT_W'(LOG_DEPTH);
		ent_fits   = valid_q[idx_s1] && (asked_q != '0) && (ent.size >= asked_q);
		ent_better = !found_q || (ent.size < best_q.size) ||
			((ent.size == best_q.size) && (ent.stamp < best_q.stamp));
		ent_end    = {1'b0, ent.start} + {1'b0, ent.size};
		rest       = best_q.size - asked_q;
		a_nstart   = best_q.start + asked_q;
		f_nstart   = left_q ? lstart_q : fs_q;
		f_nsize    = {1'b0, flen_q} + (left_q ? {1'b0, lsize_q} : 32'd0)
			+ (right_q ? {1'b0, rsize_q} : 32'd0);
		f_ovf      = !left_q && !right_q && !empty_q;
	end

	// lowest free slot once the neighbours are dropped
	always_comb begin
		slot_a = empty_q ? empty_idx_q : {FT_AW{1'b1}};
		if (left_q && (!empty_q || left_idx_q < slot_a)) begin
			slot_a = left_idx_q;
		end
		slot = slot_a;
		if (right_q && ((!empty_q && !left_q) || right_idx_q < slot_a)) begin
			slot = right_idx_q;
		end
	end

	// RAM write ports
	always_comb begin
		ft_we     = 1'b0;
		ft_waddr  = best_idx_q;
		ft_wdata  = '{start: a_nstart, size: rest, stamp: ins_ctr_q};
		log_we    = 1'b0;
		log_waddr = req_count_q[LOG_AW-1:0];
		log_wdata = '{start: '0, size: '0, ok: 1'b0};
		case (state_q)
			ST_A_WR: begin
				ft_we     = found_q && (rest != '0);
				log_we    = log_room;
				log_wdata = '{start: found_q ? best_q.start : 31'd0, size: asked_q,
					ok: found_q};
			end
			ST_F_CHK: begin
				log_we = !usable && log_room;
			end
			ST_F_LOG: begin
				log_we = !log_rd.ok && log_room;
			end
			ST_F_WR: begin
				ft_we    = !f_ovf;
				ft_waddr = slot;
				ft_wdata = '{start: f_nstart, size: f_nsize[30:0], stamp: ins_ctr_q};
				if (f_ovf) begin
					log_we = log_room;
				end else begin
					log_we    = 1'b1;
					log_waddr = tgt_m1[LOG_AW-1:0];
					log_wdata = '{start: fs_q, size: flen_q, ok: 1'b0};
				end
			end
			ST_F_LOGCUR: begin
				log_we = log_room;
			end
			default: begin
			end
		endcase
	end

	// sequencer, scan datapath and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mem_size_q  <= MEM_SIZE_RST;
			init0_q     <= 1'b1;
			valid_q     <= FT_DEPTH'(1);
			req_count_q <= '0;
			ins_ctr_q   <= 32'd1;
			cmd_q       <= CMD_ALLOC;
			asked_q     <= '0;
			target_q    <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_q      <= '0;
			fs_q        <= '0;
			flen_q      <= '0;
			fend_q      <= '0;
			left_q      <= 1'b0;
			right_q     <= 1'b0;
			empty_q     <= 1'b0;
			left_idx_q  <= '0;
			right_idx_q <= '0;
			empty_idx_q <= '0;
			lstart_q    <= '0;
			lsize_q     <= '0;
			rsize_q     <= '0;
			done_q      <= 1'b0;
			granted_q   <= 1'b0;
			addr_q      <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;

			// issue one table read per cycle while scanning
			if (state_q == ST_SCAN && !cnt_q[FT_AW]) begin
				vld_s1 <= 1'b1;
				idx_s1 <= cnt_q[FT_AW-1:0];
				cnt_q  <= cnt_q + 1'b1;
			end

			// evaluate the returned entry
			if (vld_s1) begin
				if (cmd_q == CMD_ALLOC) begin
					if (ent_fits && ent_better) begin
						found_q    <= 1'b1;
						best_idx_q <= idx_s1;
						best_q     <= ent;
					end
				end else if (valid_q[idx_s1]) begin
					if (ent_end == {1'b0, fs_q}) begin
						left_q     <= 1'b1;
						left_idx_q <= idx_s1;
						lstart_q   <= ent.start;
						lsize_q    <= ent.size;
					end
					if ({1'b0, ent.start} == fend_q) begin
						right_q     <= 1'b1;
						right_idx_q <= idx_s1;
						rsize_q     <= ent.size;
					end
				end else if (!empty_q) begin
					empty_q     <= 1'b1;
					empty_idx_q <= idx_s1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						mem_size_q  <= cfg_wdata;
						init0_q     <= 1'b1;
						valid_q     <= FT_DEPTH'(cfg_wdata != '0);
						req_count_q <= '0;
						ins_ctr_q   <= 32'd1;
					end else if (start) begin
						cmd_q    <= command;
						asked_q  <= alloc_size;
						target_q <= request_number;
						cnt_q    <= '0;
						found_q  <= 1'b0;
						left_q   <= 1'b0;
						right_q  <= 1'b0;
						empty_q  <= 1'b0;
						state_q  <= (command == CMD_ALLOC) ? ST_SCAN : ST_F_CHK;
					end
				end
				ST_F_CHK: begin
					if (usable) begin
						state_q <= ST_F_LOG;
					end else begin
						if (log_room) req_count_q <= req_count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_F_LOG: begin
					fs_q   <= log_rd.start;
					flen_q <= log_rd.size;
					fend_q <= {1'b0, log_rd.start} + {1'b0, log_rd.size};
					if (log_rd.ok) begin
						state_q <= ST_SCAN;
					end else begin
						if (log_room) req_count_q <= req_count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					// last read is evaluated in this cycle
					if (cnt_q[FT_AW]) begin
						state_q <= (cmd_q == CMD_ALLOC) ? ST_A_WR : ST_F_WR;
					end
				end
				ST_A_WR: begin
					if (found_q) begin
						if (rest != '0) begin
							ins_ctr_q <= ins_ctr_q + 1'b1;
							if (best_idx_q == '0) init0_q <= 1'b0;
						end else begin
							valid_q[best_idx_q] <= 1'b0;
						end
					end
					if (log_room) req_count_q <= req_count_q + 1'b1;
					done_q    <= 1'b1;
					granted_q <= found_q;
					addr_q    <= found_q ? best_q.start : 31'd0;
					state_q   <= ST_IDLE;
				end
				ST_F_WR: begin
					if (f_ovf) begin
						if (log_room) req_count_q <= req_count_q + 1'b1;
						done_q    <= 1'b1;
						granted_q <= 1'b0;
						addr_q    <= '0;
						state_q   <= ST_IDLE;
					end else begin
						// drop merged neighbours, then place the new block
						if (left_q) valid_q[left_idx_q] <= 1'b0;
						if (right_q) valid_q[right_idx_q] <= 1'b0;
						valid_q[slot] <= 1'b1;
						if (slot == '0) init0_q <= 1'b0;
						ins_ctr_q <= ins_ctr_q + 1'b1;
						state_q   <= ST_F_LOGCUR;
					end
				end
				ST_F_LOGCUR: begin
					if (log_room) req_count_q <= req_count_q + 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign granted       = granted_q;
	assign start_address = addr_q;

endmodule

// ===== rtl/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
	parameter int W  = 8,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== test/best_fit_allocator_with_coalescing_tb.sv =====
// ----------------------------------------------------------------------------
// best_fit_allocator_with_coalescing_tb
// Drives allocate and free commands into the allocator, keeps its own copy of
// the free table and request log to predict each grant, and compares every
// result beat with the oldest predicted one. Runs several memory sizes,
// including the smallest and largest, and fills the free table to overflow.
// ----------------------------------------------------------------------------
module best_fit_allocator_with_coalescing_tb;
	import bfa_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 300;

	// Predicts grants from a private copy of the allocator state.
	class alloc_scoreboard;
		bit [31:0] blk_start[FT_DEPTH];
		bit [31:0] blk_size[FT_DEPTH];
		bit [31:0] blk_stamp[FT_DEPTH];
		bit        blk_valid[FT_DEPTH];
		bit [31:0] req_start[LOG_DEPTH];
		bit [31:0] req_size[LOG_DEPTH];
		bit        req_ok[LOG_DEPTH];
		int unsigned req_count;
		bit [31:0] next_stamp;
		bit        want_grant[$];
		bit [30:0] want_addr[$];
		int        errors;

		function void restart(bit [30:0] cells);
			for (int i = 0; i < FT_DEPTH; i++) begin
				blk_valid[i] = 0;
				blk_stamp[i] = 0;
			end
			for (int i = 0; i < LOG_DEPTH; i++)
				req_ok[i] = 0;
			if (cells != 0) begin
				blk_start[0] = 1;
				blk_size[0] = {1'b0, cells};
				blk_valid[0] = 1;
			end
			req_count = 0;
			next_stamp = 1;
		endfunction

		function void put_block(int slot, bit [31:0] s, bit [31:0] z);
			blk_start[slot] = s;
			blk_size[slot] = z;
			blk_stamp[slot] = next_stamp;
			blk_valid[slot] = 1;
			next_stamp = next_stamp + 1;
		endfunction

		function void log_req(bit [31:0] s, bit [31:0] z, bit ok);
			if (req_count < LOG_DEPTH) begin
				req_start[req_count] = s;
				req_size[req_count] = z;
				req_ok[req_count] = ok;
				req_count++;
			end
		endfunction

		// Note one accepted command beat and queue the grant it causes.
		function void note_command(bit cmd, bit [30:0] asked, bit [12:0] num);
			int best, left, right, slot;
			bit [31:0] s, len, fin, nstart, nsize;
			best = -1;
			left = -1;
			right = -1;
			slot = -1;
			if (cmd == CMD_ALLOC) begin
				if (asked != 0)
					for (int i = 0; i < FT_DEPTH; i++) begin
						if (!blk_valid[i] || blk_size[i] < asked)
							continue;
						if (best < 0 || blk_size[i] < blk_size[best] ||
						    (blk_size[i] == blk_size[best] &&
						     blk_stamp[i] < blk_stamp[best]))
							best = i;
					end
				if (best < 0) begin
					log_req(0, {1'b0, asked}, 0);
					want_grant.push_back(0);
					want_addr.push_back('0);
				end else begin
					s = blk_start[best];
					blk_valid[best] = 0;
					if (blk_size[best] != asked)
						put_block(best, s + asked, blk_size[best] - asked);
					log_req(s, {1'b0, asked}, 1);
					want_grant.push_back(1);
					want_addr.push_back(s[30:0]);
				end
				return;
			end
			// free: merge with touching neighbors, overflow if no room
			if (num >= 1 && num <= req_count && req_ok[num - 1]) begin
				s = req_start[num - 1];
				len = req_size[num - 1];
				fin = s + len;
				for (int i = 0; i < FT_DEPTH; i++) begin
					if (!blk_valid[i])
						continue;
					if (blk_start[i] + blk_size[i] == s)
						left = i;
					if (blk_start[i] == fin)
						right = i;
				end
				nstart = s;
				nsize = len;
				if (left >= 0) begin
					nstart = blk_start[left];
					nsize = nsize + blk_size[left];
					blk_valid[left] = 0;
				end
				if (right >= 0) begin
					nsize = nsize + blk_size[right];
					blk_valid[right] = 0;
				end
				for (int i = 0; i < FT_DEPTH; i++)
					if (!blk_valid[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					want_grant.push_back(0);
					want_addr.push_back('0);
				end else begin
					put_block(slot, {1'b0, nstart[30:0]}, {1'b0, nsize[30:0]});
					req_ok[num - 1] = 0;
				end
			end
			log_req(0, 0, 0);
		endfunction

		// Compare one result beat with the oldest prediction.
		function void check_result(bit g, bit [30:0] a);
			bit eg;
			bit [30:0] ea;
			if (want_grant.size() == 0) begin
				$display("%0t: unexpected result granted=%0d start_address=%0d",
					$time, g, a);
				errors++;
				return;
			end
			eg = want_grant.pop_front();
			ea = want_addr.pop_front();
			if (g !== eg) begin
				$display("%0t: granted expected %0d actual %0d", $time, eg, g);
				errors++;
			end
			if (a !== ea) begin
				$display("%0t: start_address expected %0d actual %0d", $time, ea, a);
				errors++;
			end
		endfunction

		function int pending();
			return want_grant.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [30:0] alloc_size;
	logic [12:0] request_number;
	logic        cfg_we;
	logic [30:0] cfg_wdata;
	logic        done;
	logic        granted;
	logic [30:0] start_address;

	alloc_scoreboard sb;
	int unsigned     cycles = 0;
	int              idle_pct;

	best_fit_allocator_with_coalescing u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.alloc_size    (alloc_size),
		.request_number(request_number),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.granted       (granted),
		.start_address (start_address)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Check every result beat; bound the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			sb.check_result(granted, start_address);
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Send one command beat, with a random idle gap first.
	task automatic send_cmd(bit cmd, bit [30:0] asked, bit [12:0] num);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			start <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1;
		command <= cmd;
		alloc_size <= asked;
		request_number <= num;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_command(cmd, asked, num);
	endtask

	// Hold off until every predicted result has arrived and the block is quiet.
	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic set_memory(bit [30:0] cells);
		drain();
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= cells;
		@(negedge clk);
		cfg_we <= 0;
		sb.restart(cells);
	endtask

	// Mostly well-formed allocate/free traffic, some noise frees.
	task automatic random_items(int n, bit [30:0] max_alloc);
		int r;
		bit [12:0] num;
		bit [30:0] asked;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 55) begin
				case ($urandom_range(19))
					0: asked = 0;
					1: asked = 31'($urandom);
					default: asked = 31'($urandom_range(max_alloc, 1));
				endcase
				send_cmd(CMD_ALLOC, asked, 0);
			end else if (r < 90) begin
				num = 13'($urandom_range(sb.req_count > 0 ? sb.req_count : 1, 1));
				for (int t = 0; t < 8 && !sb.req_ok[num - 1]; t++)
					num = 13'($urandom_range(sb.req_count > 0 ? sb.req_count : 1, 1));
				send_cmd(CMD_FREE, 31'($urandom), num);
			end else begin
				case ($urandom_range(2))
					0: num = 0;
					1: num = 13'($urandom_range(8191, sb.req_count + 1));
					default: num = 13'($urandom_range(sb.req_count + 1, 1));
				endcase
				send_cmd(CMD_FREE, 31'($urandom), num);
			end
		end
	endtask

	initial begin
		sb = new();
		sb.restart(MEM_SIZE_RST);
		idle_pct = 0;
		arst_n = 0;
		start = 0;
		command = CMD_ALLOC;
		alloc_size = 0;
		request_number = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: zero size, too large, best fit, merges, bad frees.
		send_cmd(CMD_ALLOC, 0, 0);
		send_cmd(CMD_ALLOC, 1025, 0);
		send_cmd(CMD_ALLOC, 100, 0);
		send_cmd(CMD_ALLOC, 200, 0);
		send_cmd(CMD_ALLOC, 100, 0);
		send_cmd(CMD_FREE, 0, 3);
		send_cmd(CMD_FREE, 0, 5);
		send_cmd(CMD_ALLOC, 50, 0);
		send_cmd(CMD_FREE, 0, 1);
		send_cmd(CMD_FREE, 0, 2);
		send_cmd(CMD_FREE, 0, 0);
		send_cmd(CMD_FREE, 31'h7fffffff, 13'h1fff);
		send_cmd(CMD_FREE, 0, 3);
		send_cmd(CMD_FREE, 0, 14);
		send_cmd(CMD_FREE, 0, 4);
		send_cmd(CMD_ALLOC, 1024, 0);

		// Smallest memory.
		set_memory(1);
		send_cmd(CMD_ALLOC, 1, 0);
		send_cmd(CMD_ALLOC, 1, 0);
		send_cmd(CMD_FREE, 0, 1);
		send_cmd(CMD_ALLOC, 1, 0);

		// Largest memory, then random traffic with light sender idling.
		idle_pct = 19;
		set_memory(31'h7fffffff);
		send_cmd(CMD_ALLOC, 31'h7fffffff, 0);
		send_cmd(CMD_FREE, 0, 1);
		send_cmd(CMD_ALLOC, 31'h40000000, 0);
		random_items(50, 31'h10000000);

		// Fill the free table with isolated cells until it overflows.
		set_memory(1200);
		for (int k = 0; k < 516; k++)
			send_cmd(CMD_ALLOC, 1, 0);
		drain();
		idle_pct = 86;
		for (int k = 1; k < 516; k += 2)
			send_cmd(CMD_FREE, 0, 13'(k));
		for (int k = 2; k <= 12; k += 2)
			send_cmd(CMD_FREE, 0, 13'(k));

		set_memory(4000);
		random_items(30, 200);

		// No idling.
		idle_pct = 0;
		set_memory(1500);
		random_items(30, 100);

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
